// ===== hdl/hufw_pkg.sv =====
// Shared types and constants for the Huffman tree walk decoder.
// Depends on nothing; hufw_walk, the top level and the checker import it.
`timescale 1ns / 1ps

package hufw_pkg;

   localparam int IDX_BITS      = 9;
   localparam int SYM_BITS      = 8;
   localparam int DATA_BITS     = 16;
   localparam int CNT_BITS      = 5;
   localparam int BIT_SEL_BITS  = 4;
   localparam int REQ_DATA_BITS = 64;
   localparam int REQ_PAD_BITS  = 7;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_DECODE = 1'b1
   } opcode_type;

   // Request word payload, last field in the lowest bits.
   typedef struct packed {
      logic [REQ_PAD_BITS-1:0] pad;
      logic [CNT_BITS-1:0]     valid_bits;
      logic [DATA_BITS-1:0]    data_word;
      logic [IDX_BITS-1:0]     right_child;
      logic [IDX_BITS-1:0]     left_child;
      logic [SYM_BITS-1:0]     node_symbol;
      logic                    node_is_leaf;
      logic [IDX_BITS-1:0]     node_index;
   } req_item_type;

   // One node table entry as held in memory.
   typedef struct packed {
      logic                is_leaf;
      logic [SYM_BITS-1:0] symbol;
      logic [IDX_BITS-1:0] left;
      logic [IDX_BITS-1:0] right;
   } node_type;

   // Accepted request handed to the walk engine.
   typedef struct packed {
      logic         vld;
      opcode_type   op;
      logic         eos;
      req_item_type item;
   } cmd_type;

   // Symbol pushed from the walk engine to the output register.
   typedef struct packed {
      logic                vld;
      logic [SYM_BITS-1:0] symbol;
      logic                last;
   } push_type;

endpackage

// ===== hdl/hufw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module hufw_ram #(
   parameter int WIDTH = 27,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/hufw_walk.sv =====
// Tree walk engine: node writes, at most one table read per code bit, pending symbol.
// Depends on hufw_pkg; drives the ports of one hufw_ram instance.
`timescale 1ns / 1ps

module hufw_walk
   import hufw_pkg::*;
#(
   parameter int NODE_COUNT = 512,
   parameter int WORD_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output logic                          ready,
   input  logic                          out_free,
   output push_type                      push,
   output logic                          ram_we,
   output logic [$clog2(NODE_COUNT)-1:0] ram_waddr,
   output logic [$bits(node_type)-1:0]   ram_wdata,
   output logic [$clog2(NODE_COUNT)-1:0] ram_raddr,
   input  logic [$bits(node_type)-1:0]   ram_rdata
);

   localparam int AW    = $clog2(NODE_COUNT);
   localparam int LIMIT = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   function automatic logic [AW-1:0] to_addr(input logic [IDX_BITS-1:0] idx);
      logic [31:0] ext;
      ext = 32'(idx);
      return ext[AW-1:0];
   endfunction

   function automatic logic in_range(input logic [IDX_BITS-1:0] idx);
      return 32'(idx) < 32'(NODE_COUNT);
   endfunction

   state_type              state_ff, state_in;
   logic [DATA_BITS-1:0]   word_ff, word_in;
   logic [CNT_BITS-1:0]    nbits_ff, nbits_in;
   logic [CNT_BITS-1:0]    bit_cnt_ff, bit_cnt_in;
   logic                   eos_ff, eos_in;
   logic                   inflight_ff, inflight_in;
   logic [IDX_BITS-1:0]    child_ff, child_in;
   logic [IDX_BITS-1:0]    pos_ff, pos_in;
   logic [IDX_BITS-1:0]    cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic [IDX_BITS-1:0]    root_l_ff, root_l_in, root_r_ff, root_r_in;
   logic                   pend_vld_ff, pend_vld_in;
   logic [SYM_BITS-1:0]    pend_sym_ff, pend_sym_in;

   node_type               rd;
   node_type               wr_node;
   logic                   stall;
   logic [IDX_BITS-1:0]    eff_l, eff_r, nxt;
   logic                   more;
   logic                   cur_bit;

   assign rd      = node_type'(ram_rdata);
   assign ready   = (state_ff == ST_IDLE);
   assign stall   = inflight_ff && rd.is_leaf && pend_vld_ff && !out_free;
   assign eff_l   = inflight_ff ? (rd.is_leaf ? root_l_ff : rd.left) : cur_l_ff;
   assign eff_r   = inflight_ff ? (rd.is_leaf ? root_r_ff : rd.right) : cur_r_ff;
   assign more    = bit_cnt_ff < nbits_ff;
   assign cur_bit = word_ff[bit_cnt_ff[BIT_SEL_BITS-1:0]];
   assign nxt     = cur_bit ? eff_r : eff_l;

   always_comb begin
      wr_node.is_leaf = cmd.item.node_is_leaf;
      wr_node.symbol  = cmd.item.node_symbol;
      wr_node.left    = cmd.item.left_child;
      wr_node.right   = cmd.item.right_child;
   end

   always_comb begin
      state_in    = state_ff;
      word_in     = word_ff;
      nbits_in    = nbits_ff;
      bit_cnt_in  = bit_cnt_ff;
      eos_in      = eos_ff;
      inflight_in = inflight_ff;
      child_in    = child_ff;
      pos_in      = pos_ff;
      cur_l_in    = cur_l_ff;
      cur_r_in    = cur_r_ff;
      root_l_in   = root_l_ff;
      root_r_in   = root_r_ff;
      pend_vld_in = pend_vld_ff;
      pend_sym_in = pend_sym_ff;
      ram_we      = 1'b0;
      ram_waddr   = to_addr(cmd.item.node_index);
      ram_wdata   = wr_node;
      ram_raddr   = to_addr(child_ff);
      push        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.vld) begin
               if (cmd.op == OP_WRITE) begin
                  if (in_range(cmd.item.node_index)) begin
                     ram_we = 1'b1;
                     // keep the root and current-node copies coherent
                     if (cmd.item.node_index == '0) begin
                        root_l_in = cmd.item.left_child;
                        root_r_in = cmd.item.right_child;
                     end
                     if (cmd.item.node_index == pos_ff) begin
                        cur_l_in = cmd.item.left_child;
                        cur_r_in = cmd.item.right_child;
                     end
                  end
               end else begin
                  word_in     = cmd.item.data_word;
                  nbits_in    = (32'(cmd.item.valid_bits) > 32'(LIMIT)) ?
                                CNT_BITS'(LIMIT) : cmd.item.valid_bits;
                  eos_in      = cmd.eos;
                  bit_cnt_in  = '0;
                  inflight_in = 1'b0;
                  state_in    = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (!stall) begin
               if (inflight_ff) begin
                  if (rd.is_leaf) begin
                     pos_in   = '0;
                     cur_l_in = root_l_ff;
                     cur_r_in = root_r_ff;
                     if (pend_vld_ff) begin
                        push.vld    = 1'b1;
                        push.symbol = pend_sym_ff;
                        push.last   = 1'b0;
                     end
                     pend_vld_in = 1'b1;
                     pend_sym_in = rd.symbol;
                  end else begin
                     pos_in   = child_ff;
                     cur_l_in = rd.left;
                     cur_r_in = rd.right;
                  end
               end
               inflight_in = 1'b0;
               if (more) begin
                  bit_cnt_in = bit_cnt_ff + 1'b1;
                  if (in_range(nxt)) begin
                     ram_raddr   = to_addr(nxt);
                     inflight_in = 1'b1;
                     child_in    = nxt;
                  end else begin
                     // child off the table: drop the code, back to root
                     pos_in   = '0;
                     cur_l_in = root_l_ff;
                     cur_r_in = root_r_ff;
                  end
               end else if (!inflight_ff) begin
                  if (eos_ff) begin
                     pos_in   = '0;
                     cur_l_in = root_l_ff;
                     cur_r_in = root_r_ff;
                  end
                  state_in = pend_vld_ff ? ST_FLUSH : ST_IDLE;
               end
            end
         end

         ST_FLUSH: begin
            if (out_free) begin
               push.vld    = 1'b1;
               push.symbol = pend_sym_ff;
               push.last   = 1'b1;
               pend_vld_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         inflight_ff <= 1'b0;
         pend_vld_ff <= 1'b0;
         pos_ff      <= '0;
         bit_cnt_ff  <= '0;
         nbits_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_in;
         pend_vld_ff <= pend_vld_in;
         pos_ff      <= pos_in;
         bit_cnt_ff  <= bit_cnt_in;
         nbits_ff    <= nbits_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      eos_ff      <= eos_in;
      child_ff    <= child_in;
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      root_l_ff   <= root_l_in;
      root_r_ff   <= root_r_in;
      pend_sym_ff <= pend_sym_in;
   end

endmodule

// ===== hdl/huffman_tree_walk_decoder.sv =====
// Top level of the Huffman tree walk decoder: request unpacking, output register.
// Depends on hufw_pkg, hufw_ram and hufw_walk.
`timescale 1ns / 1ps

// Usage
//   req_* : request words. req_tuser selects a node write (0) or a decode (1).
//           A node write loads one table entry (leaf flag, symbol, children).
//           A decode carries up to 16 code bits, consumed from bit 0 upward;
//           req_tlast marks end of stream and returns the walk to the root.
//   rsp_* : one word per decoded symbol; rsp_tlast flags the last symbol
//           decoded from a request word.
// Timing
//   A node write leaves the engine idle. A decode holds the engine from
//   acceptance to the next acceptance: the accept, at most one node table
//   read per code bit (the dependent read through the single node port sets
//   the pace), a drain and, if it yields a symbol, the release of the
//   held-back last symbol. req_tready is high only while the walk engine is
//   idle.
// Reset
//   Synchronous reset puts the walk at the root and empties the output.
//   The node table is not cleared; load it before decoding.
// Stall
//   When rsp_tready is low the output register holds, one symbol waits in
//   the engine, and the walk pauses at its next leaf until the register frees up.

module huffman_tree_walk_decoder
   import hufw_pkg::*;
#(
   parameter int NODE_COUNT = 512,
   parameter int WORD_BITS  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // node_index, node_is_leaf, node_symbol, left_child, right_child,
   // data_word, valid_bits, zero pad (lowest bit up)
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic                     req_tuser,
   input  logic                     req_tlast,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // symbol
   output logic [SYM_BITS-1:0]      rsp_tdata,
   output logic                     rsp_tlast
);

   localparam int AW = $clog2(NODE_COUNT);
   localparam int NW = $bits(node_type);

   cmd_type             cmd;
   push_type            push;
   logic                walk_ready;
   logic                out_free;
   logic                ram_we;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [NW-1:0]       ram_wdata, ram_rdata;

   logic                rsp_vld_ff, rsp_vld_in;
   logic [SYM_BITS-1:0] rsp_sym_ff, rsp_sym_in;
   logic                rsp_last_ff, rsp_last_in;

   // unpack the accepted request word
   always_comb begin
      cmd.vld  = req_tvalid && walk_ready;
      cmd.op   = opcode_type'(req_tuser);
      cmd.eos  = req_tlast;
      cmd.item = req_item_type'(req_tdata);
   end

   assign req_tready = walk_ready;

   // output register frees when empty or being taken this cycle
   assign out_free = !rsp_vld_ff || rsp_tready;

   hufw_ram #(
      .WIDTH (NW),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   hufw_walk #(
      .NODE_COUNT (NODE_COUNT),
      .WORD_BITS  (WORD_BITS)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .ready     (walk_ready),
      .out_free  (out_free),
      .push      (push),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // load on push, hold while stalled, drop once taken
   always_comb begin
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_sym_in  = rsp_sym_ff;
      rsp_last_in = rsp_last_ff;
      if (push.vld) begin
         rsp_vld_in  = 1'b1;
         rsp_sym_in  = push.symbol;
         rsp_last_in = push.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sym_ff  <= rsp_sym_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_sym_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hdl/hufw_checker.sv =====
// Port-level checks for the Huffman tree walk decoder, bound to the top level.
// Depends on hufw_pkg and huffman_tree_walk_decoder.
`timescale 1ns / 1ps

module hufw_checker
   import hufw_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [SYM_BITS-1:0] rsp_tdata,
   input logic                rsp_tlast
);

   // after reset: output empty and ready for a request
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("not idle after reset");

   // stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled response changed");

   // the engine is busy right after a decode is taken
   a_decode_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_DECODE)) |=> !req_tready)
      else $error("request taken right after a decode");

   // no symbol can appear the cycle after any request is taken
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response appeared too early");

endmodule

bind huffman_tree_walk_decoder hufw_checker u_hufw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
